@@ hdl/e2r_pkg.sv @@
package e2r_pkg;

  localparam int AngleW     = 16;
  localparam int OutW       = 16;
  localparam int QBits      = 30;
  localparam int TrigW      = 34;
  localparam int ZW         = 36;
  localparam int AtanCount  = 32;
  localparam int HalfTurn   = 23040;
  localparam int QuartTurn  = 11520;
  localparam int FullTurn   = 46080;
  localparam int AngleShift = 16;
  localparam logic signed [TrigW-1:0] CordicX0 = 34'sd652032874;
  localparam logic signed [TrigW-1:0] OneQ30   = 34'sd1073741824;

  typedef logic signed [TrigW-1:0] trig_t;
  typedef logic signed [ZW-1:0]    zang_t;

  typedef struct packed {
    trig_t s;
    trig_t c;
  } sincos_t;

  function automatic zang_t atan_step(input int unsigned i);
    zang_t v;
    unique case (i)
      0: v = 36'sd377487360;
      1: v = 36'sd222843801;
      2: v = 36'sd117744544;
      3: v = 36'sd59768969;
      4: v = 36'sd30000467;
      5: v = 36'sd15014858;
      6: v = 36'sd7509261;
      7: v = 36'sd3754860;
      8: v = 36'sd1877459;
      9: v = 36'sd938733;
      10: v = 36'sd469367;
      11: v = 36'sd234683;
      12: v = 36'sd117342;
      13: v = 36'sd58671;
      14: v = 36'sd29335;
      15: v = 36'sd14668;
      16: v = 36'sd7334;
      17: v = 36'sd3667;
      18: v = 36'sd1833;
      19: v = 36'sd917;
      20: v = 36'sd458;
      21: v = 36'sd229;
      22: v = 36'sd115;
      23: v = 36'sd57;
      24: v = 36'sd29;
      25: v = 36'sd14;
      26: v = 36'sd7;
      27: v = 36'sd4;
      28: v = 36'sd2;
      29: v = 36'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic trig_t clamp_one(input trig_t v);
    trig_t r;
    if (v > OneQ30) begin
      r = OneQ30;
    end else if (v < -OneQ30) begin
      r = -OneQ30;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ hdl/e2r_cordic.sv @@
module e2r_cordic
  import e2r_pkg::*;
#(
  parameter int ITERS = 16
) (
  input  logic                     clk,
  input  logic signed [AngleW-1:0] angle,
  output sincos_t                  sc
);

  localparam int Steps = (ITERS > AtanCount) ? AtanCount : ITERS;

  trig_t x_r [Steps+1];
  trig_t y_r [Steps+1];
  zang_t z_r [Steps+1];
  logic  neg_r [Steps+1];
  sincos_t sc_r;

  logic signed [AngleW+1:0] a0, a1, a2;
  logic neg0;

  always_comb begin
    a0 = AngleW'(0) + (AngleW+2)'(angle);
    if (a0 > (AngleW+2)'(HalfTurn)) begin
      a1 = a0 - (AngleW+2)'(FullTurn);
    end else if (a0 < -(AngleW+2)'(HalfTurn)) begin
      a1 = a0 + (AngleW+2)'(FullTurn);
    end else begin
      a1 = a0;
    end
    neg0 = 1'b0;
    a2 = a1;
    if (a1 > (AngleW+2)'(QuartTurn)) begin
      a2 = (AngleW+2)'(HalfTurn) - a1;
      neg0 = 1'b1;
    end else if (a1 < -(AngleW+2)'(QuartTurn)) begin
      a2 = -(AngleW+2)'(HalfTurn) - a1;
      neg0 = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    x_r[0]   <= CordicX0;
    y_r[0]   <= '0;
    z_r[0]   <= ZW'(a2) <<< AngleShift;
    neg_r[0] <= neg0;
  end

  for (genvar i = 0; i < Steps; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!z_r[i][ZW-1]) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - atan_step(i);
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + atan_step(i);
      end
      neg_r[i+1] <= neg_r[i];
    end
  end

  always_ff @(posedge clk) begin
    sc_r.s <= clamp_one(y_r[Steps]);
    sc_r.c <= neg_r[Steps] ? -clamp_one(x_r[Steps]) : clamp_one(x_r[Steps]);
  end

  assign sc = sc_r;

endmodule

@@ hdl/e2r_merge.sv @@
module e2r_merge
  import e2r_pkg::*;
#(
  parameter int FRAC = 14
) (
  input  logic                   clk,
  input  sincos_t                scx,
  input  sincos_t                scy,
  input  sincos_t                scz,
  output logic signed [OutW-1:0] m_out [9]
);

  localparam int F  = (FRAC > QBits) ? QBits : ((FRAC < 0) ? 0 : FRAC);
  localparam int Sh = QBits - F;
  localparam int PW = 2 * TrigW;

  function automatic trig_t qmul(input trig_t a, input trig_t b);
    logic signed [PW-1:0] p;
    p = PW'(a) * PW'(b) + (PW'(1) <<< (QBits - 1));
    return TrigW'(p >>> QBits);
  endfunction

  function automatic logic signed [OutW-1:0] to_out(input logic signed [TrigW:0] v);
    logic signed [TrigW+1:0] r;
    logic signed [TrigW+1:0] lim;
    if (Sh == 0) begin
      r = (TrigW+2)'(v);
    end else begin
      r = ((TrigW+2)'(v) + ((TrigW+2)'(1) <<< (Sh > 0 ? Sh - 1 : 0))) >>> Sh;
    end
    lim = (TrigW+2)'(1) <<< F;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    if (r > (TrigW+2)'(32767)) r = (TrigW+2)'(32767);
    if (r < -(TrigW+2)'(32768)) r = -(TrigW+2)'(32768);
    return OutW'(r);
  endfunction

  trig_t sxsy_r, cxsy_r, cycz_r, cysz_r, szcx_r, czcx_r, sxcy_r, szsx_r, czsx_r, cxcy_r;
  trig_t sy_r, cz_r, sz_r;
  trig_t a0_r, a1_r, a3_r, a4_r, a6_r, a7_r;
  trig_t b3_r, b4_r, b6_r, b7_r, a2_r, a5_r, a8_r;
  logic signed [OutW-1:0] m_r [9];

  always_ff @(posedge clk) begin
    sxsy_r <= qmul(scx.s, scy.s);
    cxsy_r <= qmul(scx.c, scy.s);
    cycz_r <= qmul(scy.c, scz.c);
    cysz_r <= qmul(scy.c, scz.s);
    szcx_r <= qmul(scz.s, scx.c);
    czcx_r <= qmul(scz.c, scx.c);
    sxcy_r <= qmul(scx.s, scy.c);
    szsx_r <= qmul(scz.s, scx.s);
    czsx_r <= qmul(scz.c, scx.s);
    cxcy_r <= qmul(scx.c, scy.c);
    sy_r   <= scy.s;
    cz_r   <= scz.c;
    sz_r   <= scz.s;

    a0_r <= cycz_r;
    a1_r <= -cysz_r;
    a2_r <= sy_r;
    a3_r <= qmul(sxsy_r, cz_r);
    b3_r <= szcx_r;
    a4_r <= -qmul(sxsy_r, sz_r);
    b4_r <= czcx_r;
    a5_r <= -sxcy_r;
    a6_r <= -qmul(cxsy_r, cz_r);
    b6_r <= szsx_r;
    a7_r <= qmul(cxsy_r, sz_r);
    b7_r <= czsx_r;
    a8_r <= cxcy_r;

    m_r[0] <= to_out((TrigW+1)'(a0_r));
    m_r[1] <= to_out((TrigW+1)'(a1_r));
    m_r[2] <= to_out((TrigW+1)'(a2_r));
    m_r[3] <= to_out((TrigW+1)'(a3_r) + (TrigW+1)'(b3_r));
    m_r[4] <= to_out((TrigW+1)'(a4_r) + (TrigW+1)'(b4_r));
    m_r[5] <= to_out((TrigW+1)'(a5_r));
    m_r[6] <= to_out((TrigW+1)'(a6_r) + (TrigW+1)'(b6_r));
    m_r[7] <= to_out((TrigW+1)'(a7_r) + (TrigW+1)'(b7_r));
    m_r[8] <= to_out((TrigW+1)'(a8_r));
  end

  assign m_out = m_r;

endmodule

@@ hdl/euler_to_rotation_matrix.sv @@
// Takes one angle triple per clock while busy is low (busy is never raised) and gives the
// matrix with out_valid high for one cycle; the pipeline length is set by the CORDIC stage
// chain, one stage per step. The receiver cannot stall the pipeline.
module euler_to_rotation_matrix
  import e2r_pkg::*;
#(
  parameter int RESULT_FRACTION_BITS = 14,
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [AngleW-1:0] in_angle_x,
  input  logic signed [AngleW-1:0] in_angle_y,
  input  logic signed [AngleW-1:0] in_angle_z,
  output logic                     out_valid,
  output logic signed [OutW-1:0]   out_m00,
  output logic signed [OutW-1:0]   out_m01,
  output logic signed [OutW-1:0]   out_m02,
  output logic signed [OutW-1:0]   out_m10,
  output logic signed [OutW-1:0]   out_m11,
  output logic signed [OutW-1:0]   out_m12,
  output logic signed [OutW-1:0]   out_m20,
  output logic signed [OutW-1:0]   out_m21,
  output logic signed [OutW-1:0]   out_m22
);

  localparam int Steps = (TRIG_ITERATIONS > AtanCount) ? AtanCount : TRIG_ITERATIONS;
  localparam int Lat = Steps + 5;

  sincos_t scx, scy, scz;
  logic signed [OutW-1:0] m [9];
  logic [Lat-1:0] vld_r;

  e2r_cordic #(.ITERS(TRIG_ITERATIONS)) u_lane_x (.clk(clk), .angle(in_angle_x), .sc(scx));
  e2r_cordic #(.ITERS(TRIG_ITERATIONS)) u_lane_y (.clk(clk), .angle(in_angle_y), .sc(scy));
  e2r_cordic #(.ITERS(TRIG_ITERATIONS)) u_lane_z (.clk(clk), .angle(in_angle_z), .sc(scz));

  e2r_merge #(.FRAC(RESULT_FRACTION_BITS)) u_merge (
    .clk(clk), .scx(scx), .scy(scy), .scz(scz), .m_out(m)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[Lat-2:0], start};
    end
  end

  assign busy = 1'b0;
  assign out_valid = vld_r[Lat-1];
  assign out_m00 = m[0];
  assign out_m01 = m[1];
  assign out_m02 = m[2];
  assign out_m10 = m[3];
  assign out_m11 = m[4];
  assign out_m12 = m[5];
  assign out_m20 = m[6];
  assign out_m21 = m[7];
  assign out_m22 = m[8];

  a_valid_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##Lat out_valid) else $error("result beat missing");
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, Lat)) else $error("unexpected result beat");

endmodule
